>>> rtl/core/sfir_pkg.sv
// Package for the symmetric FIR row filter: register map, field widths and reset values.
// No dependencies; imported by symmetric_fir_row_filter.
package sfir_pkg;

  // Default sizing
  localparam int unsigned MAX_TAPS_DEF    = 7;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned TAP_W     = 3;
  localparam int unsigned NUM_COEF  = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_0    = 3'd1;

  // Reset values
  localparam logic [TAP_W-1:0]         TAP_COUNT_RST = 3'd1;
  localparam logic signed [COEF_W-1:0] COEF_0_RST    = 16'sd32767;
  localparam logic signed [COEF_W-1:0] COEF_N_RST    = 16'sd0;

  // Fraction bits of the Q1.15 coefficients; the rounding offset is half an LSB of the result
  localparam int unsigned FRAC_BITS = 15;

endpackage

>>> rtl/core/symmetric_fir_row_filter.sv
// Datapath: an accepted request enters the window, then its result is registered in psum_q,
// prod_q and the output register. Throughput: one request per cycle within a row while
// results are not stalled. A request flagged row_end holds off input while the row tail
// drains with zeros shifting into the window, and also while results are stalled.
// Reset (rst_ni, asynchronous, active low): tap_count 1, coef_0 32767, other taps 0,
// window and row fill cleared, pipeline empty.
// Symmetric FIR row filter: window shift line, pre-add, multiply, sum/round/saturate.
// Depends on sfir_pkg.
module symmetric_fir_row_filter #(
  parameter int unsigned MAX_TAPS    = sfir_pkg::MAX_TAPS_DEF,
  parameter int unsigned SAMPLE_BITS = sfir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [sfir_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfir_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  logic                            row_end_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]   filtered_o,
  output logic                            row_done_o,
  output logic                            clipped_o
);
  import sfir_pkg::*;

  localparam int unsigned WIN    = 2 * MAX_TAPS - 1;
  localparam int unsigned FILL_W = $clog2(MAX_TAPS + 1);
  localparam int unsigned PSUM_W = SAMPLE_BITS + 1;
  localparam int unsigned PROD_W = PSUM_W + COEF_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int unsigned RES_W  = ACC_W - FRAC_BITS;

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_TAPS);
  localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

  localparam logic signed [RES_W-1:0] SAT_HI =
    RES_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [TAP_W-1:0]         tap_q;
  logic signed [COEF_W-1:0] coef_q [NUM_COEF];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= TAP_COUNT_RST;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_q[i] <= (i == 0) ? COEF_0_RST : COEF_N_RST;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TAP_COUNT) begin
        tap_q <= cfg_wdata_i[TAP_W-1:0];
      end else begin
        coef_q[cfg_idx_i - CFG_COEF_0] <= cfg_wdata_i;
      end
    end
  end

  // Effective tap count: zero reads as one, clamp at MAX_TAPS
  logic [FILL_W-1:0] taps;
  logic [FILL_W-1:0] centre;

  always_comb begin
    if (tap_q == '0) begin
      taps = FILL_ONE;
    end else if (int'(tap_q) > int'(MAX_TAPS)) begin
      taps = FILL_MAX;
    end else begin
      taps = FILL_W'(tap_q);
    end
    centre = taps - FILL_ONE;
  end

  // ---------------------------------------------------------------------------
  // Handshake and control state
  logic en;
  logic accept;
  logic issue;
  logic issue_done;
  logic flush_skip;
  logic flush_emit;

  logic signed [SAMPLE_BITS-1:0] win_q [WIN];
  logic signed [SAMPLE_BITS-1:0] win_d [WIN];
  logic [FILL_W-1:0]             fill_q, fill_d;
  logic [FILL_W-1:0]             fskip_q, fskip_d;
  logic [FILL_W-1:0]             fleft_q, fleft_d;
  logic                          flush_q, flush_d;
  logic                          pend_q, pend_d;
  logic [FILL_W-1:0]             fill_new;
  logic [FILL_W-1:0]             have;

  logic                          out_valid_q;

  // Whole pipeline advances unless a finished result is held up
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = flush_q || !en;
  assign accept     = in_valid_i && !in_stall_o;

  assign flush_skip = flush_q && (fskip_q != '0);
  assign flush_emit = flush_q && (fskip_q == '0) && en;
  assign issue      = en && (pend_q || (flush_q && (fskip_q == '0)));
  assign issue_done = flush_q && (fleft_q == FILL_ONE);

  assign fill_new = (fill_q < FILL_MAX) ? fill_q + FILL_ONE : fill_q;
  assign have     = (fill_new < taps) ? fill_new : taps;

  // Window and row bookkeeping
  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    fskip_d = fskip_q;
    fleft_d = fleft_q;
    flush_d = flush_q;
    pend_d  = pend_q;

    if (en) begin
      pend_d = accept && !row_end_i && (fill_new >= taps);
    end

    if (accept) begin
      win_d[0] = sample_i;
      for (int i = 1; i < WIN; i++) begin
        win_d[i] = win_q[i-1];
      end
      fill_d = fill_new;
      if (row_end_i) begin
        // tail drain: shift zeros until the oldest owed output sits at the centre
        flush_d = 1'b1;
        fskip_d = taps - have;
        fleft_d = have;
      end
    end else if (flush_skip) begin
      win_d[0] = '0;
      for (int i = 1; i < WIN; i++) begin
        win_d[i] = win_q[i-1];
      end
      fskip_d = fskip_q - FILL_ONE;
    end else if (flush_emit) begin
      if (fleft_q == FILL_ONE) begin
        // last output of the row: clear for the next row
        for (int i = 0; i < WIN; i++) begin
          win_d[i] = '0;
        end
        fill_d  = '0;
        flush_d = 1'b0;
      end else begin
        win_d[0] = '0;
        for (int i = 1; i < WIN; i++) begin
          win_d[i] = win_q[i-1];
        end
        fleft_d = fleft_q - FILL_ONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN; i++) begin
        win_q[i] <= '0;
      end
      fill_q  <= '0;
      fskip_q <= '0;
      fleft_q <= '0;
      flush_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      win_q   <= win_d;
      fill_q  <= fill_d;
      fskip_q <= fskip_d;
      fleft_q <= fleft_d;
      flush_q <= flush_d;
      pend_q  <= pend_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pick taps around the centre and pre-add the mirrored pairs
  logic signed [PSUM_W-1:0] psum_d [MAX_TAPS];
  logic signed [PSUM_W-1:0] psum_q [MAX_TAPS];
  logic                     v1_q, done1_q;

  always_comb begin
    for (int s = 0; s < MAX_TAPS; s++) begin
      psum_d[s] = '0;
      for (int k = 0; k < MAX_TAPS; k++) begin
        if (centre == FILL_W'(k)) begin
          if (s == 0) begin
            psum_d[s] = PSUM_W'(win_q[k]);
          end else if (s <= k) begin
            psum_d[s] = PSUM_W'(win_q[k+s]) + PSUM_W'(win_q[k-s]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      psum_q  <= psum_d;
      done1_q <= issue_done;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: one multiplier per tap
  logic signed [PROD_W-1:0] prod_q [MAX_TAPS];
  logic                     v2_q, done2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < MAX_TAPS; s++) begin
        prod_q[s] <= PROD_W'(psum_q[s]) * PROD_W'(coef_q[s]);
      end
      done2_q <= done1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sum, round half up (floor of acc + 2^14), saturate
  logic signed [ACC_W-1:0] acc;
  logic signed [RES_W-1:0] res;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                    clip;

  always_comb begin
    acc = RND;
    for (int s = 0; s < MAX_TAPS; s++) begin
      acc = acc + ACC_W'(prod_q[s]);
    end
    res = acc[ACC_W-1:FRAC_BITS];
    if (res > SAT_HI) begin
      sat  = SAT_HI[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end else if (res < SAT_LO) begin
      sat  = SAT_LO[SAMPLE_BITS-1:0];
      clip = 1'b1;
    end else begin
      sat  = res[SAMPLE_BITS-1:0];
      clip = 1'b0;
    end
  end

  // Output register
  logic signed [SAMPLE_BITS-1:0] filt_q;
  logic                          done_q, clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      filt_q <= sat;
      done_q <= done2_q;
      clip_q <= clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filt_q;
  assign row_done_o  = done_q;
  assign clipped_o   = clip_q;

endmodule

>>> sim/symmetric_fir_row_filter_test.sv
// Self-checking testbench for the symmetric FIR row filter: a row predictor, request driver,
// result monitor and random stall pacing. Depends on sfir_pkg and symmetric_fir_row_filter.
`timescale 1ns / 1ps

module symmetric_fir_row_filter_test;
  import sfir_pkg::*;

  localparam int     CLK_PERIOD   = 12;
  localparam int     SAMPLE_W     = SAMPLE_BITS_DEF;
  localparam int     TAPS_MAX     = MAX_TAPS_DEF;
  localparam int     WIN_LEN      = 2 * TAPS_MAX - 1;
  localparam int     DRAIN_CYCLES = 24;
  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     PHASE_ITEMS  = 24;
  localparam longint SAT_HI       = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO       = -SAT_HI - 1;

  localparam logic signed [COEF_W-1:0]   COEF_MAX = 16'sh7FFF;
  localparam logic signed [COEF_W-1:0]   COEF_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SMP_MAX  = SAT_HI[SAMPLE_W-1:0];
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN  = SAT_LO[SAMPLE_W-1:0];

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       row_end;
  } request_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       row_done;
    logic                       clipped;
  } result_t;

  // DUT ports
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i   = '0;
  logic [CFG_DAT_W-1:0]       cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       row_end_i   = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] filtered_o;
  logic                       row_done_o;
  logic                       clipped_o;

  // predictor copy of the registers and the row window
  logic [TAP_W-1:0]           tap_cfg;
  logic signed [COEF_W-1:0]   coef_q [NUM_COEF];
  logic signed [SAMPLE_W-1:0] win_q  [WIN_LEN];
  int                         fill_cnt;

  // coefficient set for the next register load
  logic signed [COEF_W-1:0]   coef_plan [NUM_COEF];

  request_t sample_backlog [$];
  result_t  owed_results   [$];

  int samples_total  = 0;
  int samples_issued = 0;
  int samples_taken  = 0;
  int results_seen   = 0;
  int results_paced  = 0;
  int fail_count     = 0;
  int cycle_count    = 0;
  int send_level     = 1;
  int recv_level     = 1;
  int send_gap       = 0;
  int recv_gap       = 0;
  int hold_req       = 0;
  int hold_left      = 0;

  symmetric_fir_row_filter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .row_end_i   (row_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .row_done_o  (row_done_o),
    .clipped_o   (clipped_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Idle length for one request: none, occasional, or anything up to 17
  function automatic int idle_draw(input int level);
    int gap;
    gap = 0;
    if (level == 2) begin
      gap = $urandom_range(0, 17);
    end else if (level == 1 && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
    end
    return gap;
  endfunction

  // One output position: centre tap plus pre-added symmetric pairs, round, saturate
  function automatic result_t filter_at(input int centre, input int taps, input logic last);
    longint  acc;
    longint  pair;
    longint  rounded;
    int      s;
    result_t res;
    acc = longint'(coef_q[0]) * longint'(win_q[centre]);
    for (s = 1; s < taps; s++) begin
      pair = longint'(win_q[centre + s]);
      // the right neighbour lies past the row end when it is not in the window yet
      if (s <= centre) pair += longint'(win_q[centre - s]);
      acc += longint'(coef_q[s]) * pair;
    end
    rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    res.row_done = last;
    res.clipped  = 1'b1;
    if (rounded > SAT_HI) begin
      res.filtered = SMP_MAX;
    end else if (rounded < SAT_LO) begin
      res.filtered = SMP_MIN;
    end else begin
      res.filtered = rounded[SAMPLE_W-1:0];
      res.clipped  = 1'b0;
    end
    return res;
  endfunction

  // Shift one sample into the row window and queue the outputs it releases
  function automatic void predict_row_step(input logic signed [SAMPLE_W-1:0] smp,
                                           input logic last);
    int taps;
    int have;
    int i;
    taps = (tap_cfg == '0) ? 1 : int'(tap_cfg);
    if (taps > TAPS_MAX) taps = TAPS_MAX;
    for (i = WIN_LEN - 1; i > 0; i--) win_q[i] = win_q[i - 1];
    win_q[0] = smp;
    if (fill_cnt < TAPS_MAX) fill_cnt++;
    have = (fill_cnt < taps) ? fill_cnt : taps;
    if (!last) begin
      if (fill_cnt >= taps) owed_results.push_back(filter_at(taps - 1, taps, 1'b0));
    end else begin
      // row end flushes every position still owed, oldest first
      for (i = have; i > 0; i--) owed_results.push_back(filter_at(i - 1, taps, i == 1));
      for (i = 0; i < WIN_LEN; i++) win_q[i] = '0;
      fill_cnt = 0;
    end
  endfunction

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Accepted requests feed the predictor; accepted results are checked in order
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_row_step(sample_i, row_end_i);
      samples_taken++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        $error("result with none owed: filtered %0d row_done %0b clipped %0b",
               filtered_o, row_done_o, clipped_o);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (filtered_o !== want.filtered) begin
          $error("filtered: expected %0d, got %0d", want.filtered, filtered_o);
          fail_count++;
        end
        if (row_done_o !== want.row_done) begin
          $error("row_done: expected %0b, got %0b", want.row_done, row_done_o);
          fail_count++;
        end
        if (clipped_o !== want.clipped) begin
          $error("clipped: expected %0b, got %0b", want.clipped, clipped_o);
          fail_count++;
        end
      end
    end
  end

  // Request driver: holds a request until taken, then idles for a drawn gap
  always @(negedge clk_i) begin : drive_requests
    request_t req;
    if (rst_ni && !(in_valid_i && samples_taken != samples_issued)) begin
      if (in_valid_i) send_gap = idle_draw(send_level);
      if (send_gap > 0 || sample_backlog.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid_i <= 1'b0;
        sample_i   <= SAMPLE_W'($urandom);
        row_end_i  <= 1'($urandom);
      end else begin
        req = sample_backlog.pop_front();
        in_valid_i <= 1'b1;
        sample_i   <= req.sample;
        row_end_i  <= req.row_end;
        samples_issued++;
      end
    end
  end

  // Result side stall: long hold-off on request, else a drawn gap per result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (results_seen != results_paced) begin
        results_paced = results_seen;
        recv_gap      = idle_draw(recv_level);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic queue_sample(input logic signed [SAMPLE_W-1:0] smp, input logic last);
    sample_backlog.push_back('{sample: smp, row_end: last});
    samples_total++;
  endtask

  task automatic wait_pipeline_drained();
    while (samples_taken != samples_total || owed_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_TAP_COUNT) tap_cfg = data[TAP_W-1:0];
    else coef_q[int'(idx) - int'(CFG_COEF_0)] = data;
  endtask

  task automatic load_filter(input logic [CFG_DAT_W-1:0] taps_word);
    int k;
    write_reg(CFG_TAP_COUNT, taps_word);
    for (k = 0; k < NUM_COEF; k++) write_reg(CFG_IDX_W'(int'(CFG_COEF_0) + k), coef_plan[k]);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] v;
    v = SAMPLE_W'($urandom);
    case ($urandom_range(0, 9))
      0:       v = SMP_MAX;
      1:       v = SMP_MIN;
      2:       v = v >>> (SAMPLE_W - 8);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    logic signed [COEF_W-1:0] c;
    c = COEF_W'($urandom);
    case ($urandom_range(0, 5))
      0:       c = COEF_MAX;
      1:       c = COEF_MIN;
      2:       c = '0;
      default: c = c >>> $urandom_range(0, 3);
    endcase
    return c;
  endfunction

  // Mostly mid-length rows, some single or two-sample rows, a few long ones
  task automatic queue_random_row(inout int count);
    int len;
    int i;
    case ($urandom_range(0, 9))
      0:       len = $urandom_range(1, 2);
      1:       len = $urandom_range(20, 40);
      default: len = $urandom_range(3, 14);
    endcase
    for (i = 0; i < len; i++) queue_sample(rand_sample(), i == len - 1);
    count += len;
  endtask

  initial begin : stimulus
    logic [CFG_DAT_W-1:0] taps_word;
    int phase;
    int count;
    int k;
    tap_cfg  = TAP_COUNT_RST;
    coef_q   = '{default: COEF_N_RST};
    coef_q[0] = COEF_0_RST;
    win_q    = '{default: '0};
    fill_cnt = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Three taps, saturating coefficients; full-scale samples then short rows
    coef_plan = '{16'sh4000, COEF_MAX, COEF_MIN, 16'sh0, 16'sh0, 16'sh0, 16'sh0};
    load_filter(16'd3);
    queue_sample(SMP_MAX, 1'b0);
    queue_sample(SMP_MAX, 1'b0);
    queue_sample(SMP_MIN, 1'b0);
    queue_sample(SMP_MIN, 1'b0);
    queue_sample(SMP_MAX, 1'b0);
    queue_sample('0, 1'b1);
    queue_sample(SMP_MIN, 1'b1);
    queue_sample(16'sd12345, 1'b0);
    queue_sample(-16'sd1, 1'b1);

    // Tap count raised in the middle of a row
    queue_sample(16'sd1000, 1'b0);
    queue_sample(-16'sd2000, 1'b0);
    queue_sample(16'sd30000, 1'b0);
    queue_sample(-16'sd30000, 1'b0);
    wait_pipeline_drained();
    write_reg(CFG_TAP_COUNT, 16'd5);
    queue_sample(16'sd7, 1'b0);
    queue_sample(SMP_MIN, 1'b0);
    queue_sample(SMP_MAX, 1'b1);

    // Tap count zero acts as one; upper data bits carry junk
    wait_pipeline_drained();
    write_reg(CFG_TAP_COUNT, 16'hFFF8);
    write_reg(CFG_COEF_0, COEF_MIN);
    queue_sample(SMP_MIN, 1'b0);
    queue_sample(SMP_MAX, 1'b0);
    queue_sample(16'sd1, 1'b1);

    // Widest window, all taps at full positive scale
    wait_pipeline_drained();
    coef_plan = '{default: COEF_MAX};
    load_filter(16'd7);
    for (k = 0; k < 8; k++) queue_sample(k[0] ? SMP_MIN : SMP_MAX, k == 7);

    // Random phases, each with its own filter and pacing
    for (phase = 0; phase < 6; phase++) begin
      wait_pipeline_drained();
      for (k = 0; k < NUM_COEF; k++) coef_plan[k] = (phase == 0) ? COEF_MIN : rand_coef();
      case (phase)
        0:       taps_word = 16'd7;
        1:       taps_word = {13'($urandom), 3'd1};
        default: taps_word = 16'($urandom);
      endcase
      load_filter(taps_word);
      send_level = (phase == 4) ? 0 : $urandom_range(1, 2);
      recv_level = (phase == 4) ? 0 : $urandom_range(1, 2);
      // long output hold-off so the block backs up into its input
      if (phase == 2) hold_req = 250;
      count = 0;
      while (count < PHASE_ITEMS) begin
        queue_random_row(count);
        // sender pauses once until every owed result has come out
        if (phase == 3 && count >= PHASE_ITEMS / 2 && count < PHASE_ITEMS / 2 + 15) begin
          while (samples_taken != samples_total || owed_results.size() != 0) @(negedge clk_i);
          count = PHASE_ITEMS / 2 + 15;
        end
      end
    end

    wait_pipeline_drained();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sfir_pkg.sv
rtl/core/symmetric_fir_row_filter.sv
sim/symmetric_fir_row_filter_test.sv
